>>> rtl/nncl_pkg.sv
// Shared types, constants and the line-count rule for the nearest-neighbor chain block.
`timescale 1ns / 1ps
`default_nettype none
package nncl_pkg;

  localparam int PT_COORD_W = 8;   // width of a coordinate field on the ports
  localparam int OUT_IDX_W  = 5;   // width of an index field on the ports
  localparam int LINE_W     = 3;   // width of a line number

  localparam int LINES_AT_15 = 15;
  localparam int LINES_AT_20 = 20;
  localparam int LINES_AT_25 = 25;
  localparam int MIN_LINES   = 2;

  typedef logic [PT_COORD_W-1:0] coord_t;
  typedef logic [OUT_IDX_W-1:0]  out_idx_t;
  typedef logic [LINE_W-1:0]     line_t;

  // Number of lines that a walk over the given number of points is split into.
  function automatic line_t line_count(input int total);
    line_t n;
    if (total >= LINES_AT_25) begin
      n = line_t'(MIN_LINES + 3);
    end else if (total >= LINES_AT_20) begin
      n = line_t'(MIN_LINES + 2);
    end else if (total >= LINES_AT_15) begin
      n = line_t'(MIN_LINES + 1);
    end else begin
      n = line_t'(MIN_LINES);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/nncl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module nncl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                             wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                             rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/nearest_neighbor_chain_lines.sv
// Top level: point store and greedy nearest-neighbor walk that emits numbered edges.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------------------
//  in_     | input     | in_valid / in_stall | one point (x, y) and its last-point flag
//  out_    | output    | out_valid/out_stall | one edge: indices, coordinates, line, last
//
// Points are stored while idle. The last point starts the walk: the line length is first
// worked out by repeated subtraction, then each edge is found by a distance scan that
// steps through the stored points over the single RAM read port, one point per cycle.
// Reset clears the point count, visited marks and walk state; the RAM is not cleared.
// in_stall is high for the whole walk; a stalled edge holds the walk until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_chain_lines #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nncl_pkg::coord_t  in_point_x,
  input  wire nncl_pkg::coord_t  in_point_y,
  input  wire logic              in_final_point,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nncl_pkg::out_idx_t     out_from_index,
  output nncl_pkg::out_idx_t     out_to_index,
  output nncl_pkg::coord_t       out_from_x,
  output nncl_pkg::coord_t       out_from_y,
  output nncl_pkg::coord_t       out_to_x,
  output nncl_pkg::coord_t       out_to_y,
  output nncl_pkg::line_t        out_line_number,
  output logic                   out_final_edge
);
  import nncl_pkg::*;

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CUR   = 3'd2;
  localparam logic [2:0] ST_CURD  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]            state_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      total_r;
  line_t                 lines_r;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W-1:0]      q_r;
  logic [CNT_W-1:0]      mc_r;
  logic [CNT_W-1:0]      step_r;
  logic [CNT_W-1:0]      j_r;
  line_t                 line_r;
  logic [IDX_W-1:0]      cur_r;
  logic [MAX_POINTS-1:0] visited_r;
  logic                  drain_r;
  logic [COORD_BITS-1:0] cx_r, cy_r;

  // Scan pipeline: RAM read, squares, then sum and compare.
  logic                  p1_vld_r;
  logic [IDX_W-1:0]      p1_idx_r;
  logic                  p2_vld_r;
  logic [IDX_W-1:0]      p2_idx_r;
  logic [COORD_BITS-1:0] p2_x_r, p2_y_r;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic                  found_r;
  logic [DIST_W-1:0]     best_d_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [COORD_BITS-1:0] best_x_r, best_y_r;

  logic                  out_valid_r;
  out_idx_t              out_from_index_r, out_to_index_r;
  coord_t                out_from_x_r, out_from_y_r, out_to_x_r, out_to_y_r;
  line_t                 out_line_r;
  logic                  out_final_r;

  logic                      in_take;
  logic                      wr_en;
  logic [CNT_W-1:0]          count_nxt;
  logic [IDX_W-1:0]          rd_addr;
  logic [2*COORD_BITS-1:0]   rd_data;
  logic [COORD_BITS-1:0]     rd_x, rd_y;
  logic [COORD_BITS-1:0]     dx, dy;
  logic [DIST_W-1:0]         dist_sum;
  logic                      out_free;
  logic                      last_edge;
  logic [CNT_W-1:0]          mc_inc;
  logic [CNT_W-1:0]          mc_nxt;
  line_t                     line_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign wr_en     = in_take && (32'(count_r) < MAX_POINTS);
  assign count_nxt = wr_en ? count_r + CNT_W'(1) : count_r;

  assign rd_addr = (state_r == ST_SCAN) ? j_r[IDX_W-1:0] : cur_r;

  nncl_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({COORD_BITS'(in_point_x), COORD_BITS'(in_point_y)}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_x     = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_y     = rd_data[COORD_BITS-1:0];
  assign dx       = (rd_x >= cx_r) ? rd_x - cx_r : cx_r - rd_x;
  assign dy       = (rd_y >= cy_r) ? rd_y - cy_r : cy_r - rd_y;
  assign dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  assign out_free  = !out_valid_r || !out_stall;
  assign last_edge = (32'(step_r) + 2) == 32'(total_r);

  // The line advances each time the incremented edge counter equals q, until the last line is reached.
  always_comb begin
    mc_inc   = mc_r + CNT_W'(1);
    mc_nxt   = mc_inc;
    line_nxt = line_r;
    if (mc_inc == q_r) begin
      mc_nxt = '0;
      if (line_r != lines_r) begin
        line_nxt = line_r + line_t'(1);
      end
    end
  end

  // Payload registers of the scan pipeline, the current point and the output edge.
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      p1_idx_r <= j_r[IDX_W-1:0];
    end
    sqx_r    <= SQ_W'(dx) * SQ_W'(dx);
    sqy_r    <= SQ_W'(dy) * SQ_W'(dy);
    p2_idx_r <= p1_idx_r;
    p2_x_r   <= rd_x;
    p2_y_r   <= rd_y;
    if (state_r == ST_CURD) begin
      cx_r <= rd_x;
      cy_r <= rd_y;
    end
    if (p2_vld_r && (!found_r || dist_sum < best_d_r)) begin
      best_d_r   <= dist_sum;
      best_idx_r <= p2_idx_r;
      best_x_r   <= p2_x_r;
      best_y_r   <= p2_y_r;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_from_index_r <= out_idx_t'(cur_r);
      out_to_index_r   <= out_idx_t'(best_idx_r);
      out_from_x_r     <= coord_t'(cx_r);
      out_from_y_r     <= coord_t'(cy_r);
      out_to_x_r       <= coord_t'(best_x_r);
      out_to_y_r       <= coord_t'(best_y_r);
      out_line_r       <= line_nxt;
      out_final_r      <= last_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      lines_r     <= line_t'(MIN_LINES);
      rem_r       <= '0;
      q_r         <= '0;
      mc_r        <= '0;
      step_r      <= '0;
      j_r         <= '0;
      line_r      <= line_t'(1);
      cur_r       <= '0;
      visited_r   <= '0;
      drain_r     <= 1'b0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_vld_r <= (state_r == ST_SCAN) && !visited_r[j_r[IDX_W-1:0]];
      p2_vld_r <= p1_vld_r;
      if (p2_vld_r) begin
        found_r <= 1'b1;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            count_r <= count_nxt;
            if (in_final_point) begin
              total_r <= count_nxt;
              lines_r <= line_count(32'(count_nxt));
              rem_r   <= count_nxt;
              q_r     <= '0;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // q = total / lines by repeated subtraction.
          if (32'(rem_r) >= 32'(lines_r)) begin
            rem_r <= rem_r - CNT_W'(lines_r);
            q_r   <= q_r + CNT_W'(1);
          end else begin
            cur_r     <= '0;
            line_r    <= line_t'(1);
            step_r    <= '0;
            mc_r      <= '0;
            visited_r <= '0;
            state_r   <= ST_CUR;
          end
        end
        ST_CUR: begin
          visited_r[cur_r] <= 1'b1;
          state_r          <= ST_CURD;
        end
        ST_CURD: begin
          if (32'(step_r) + 1 >= 32'(total_r)) begin
            // Every point is visited: the walk ends without an edge.
            count_r   <= '0;
            visited_r <= '0;
            cur_r     <= '0;
            line_r    <= line_t'(1);
            step_r    <= '0;
            mc_r      <= '0;
            state_r   <= ST_IDLE;
          end else begin
            j_r     <= '0;
            found_r <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          j_r <= j_r + CNT_W'(1);
          if (j_r == total_r - CNT_W'(1)) begin
            drain_r <= 1'b0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_r <= 1'b1;
          if (drain_r) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            mc_r        <= mc_nxt;
            line_r      <= line_nxt;
            if (last_edge) begin
              count_r   <= '0;
              visited_r <= '0;
              cur_r     <= '0;
              line_r    <= line_t'(1);
              step_r    <= '0;
              mc_r      <= '0;
              state_r   <= ST_IDLE;
            end else begin
              cur_r   <= best_idx_r;
              step_r  <= step_r + CNT_W'(1);
              state_r <= ST_CUR;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_from_index  = out_from_index_r;
  assign out_to_index    = out_to_index_r;
  assign out_from_x      = out_from_x_r;
  assign out_from_y      = out_from_y_r;
  assign out_to_x        = out_to_x_r;
  assign out_to_y        = out_to_y_r;
  assign out_line_number = out_line_r;
  assign out_final_edge  = out_final_r;

endmodule
`default_nettype wire
